// ===== rtl/planar_arm_collision_check_defines.svh =====
// ---------------------------------------------------------------------------
// planar arm collision check assertion macros
// shared property wrappers, clocked on clk_i and disabled in reset
// ---------------------------------------------------------------------------
`ifndef PLANAR_ARM_COLLISION_CHECK_DEFINES_SVH
`define PLANAR_ARM_COLLISION_CHECK_DEFINES_SVH

// same-cycle implication
`define PACC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define PACC_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== rtl/pacc_pkg.sv =====
// ---------------------------------------------------------------------------
// pacc_pkg
// shared constants, types and helper functions of the arm collision check
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pacc_pkg;

  localparam int CordicIterations = 14;
  localparam int AtanEntries      = 24;
  localparam int IterW            = $clog2(AtanEntries);
  localparam int NumLanes         = 3;
  localparam int NumObst          = 4;
  localparam int CfShift          = 30;
  localparam int CfW              = 33;
  localparam int AngW             = 16;
  localparam int SumW             = 18;
  localparam int CoordW           = 16;
  localparam int LenW             = 13;
  localparam int CfgW             = 64;
  localparam int CfgAddrW         = 3;

  localparam logic signed [18:0] AngPi     = 19'sd25736;
  localparam logic signed [18:0] AngHalfPi = 19'sd12868;
  localparam logic signed [18:0] AngTwoPi  = 19'sd51472;
  localparam logic signed [CfW-1:0] CfGain = 33'sd652032874;

  typedef enum logic [CfgAddrW-1:0] {
    RegObst0 = 3'd0,
    RegObst1 = 3'd1,
    RegObst2 = 3'd2,
    RegObst3 = 3'd3,
    RegLen1  = 3'd4,
    RegLen2  = 3'd5,
    RegLen3  = 3'd6,
    RegWidth = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CfW-1:0] x;
    logic signed [CfW-1:0] y;
    logic signed [CfW-1:0] z;
    logic                  neg;
  } lane_t;

  typedef lane_t [NumLanes-1:0] lanes_t;

  function automatic logic signed [CfW-1:0] atan_entry(input logic [IterW-1:0] idx);
    logic signed [CfW-1:0] r;
    unique case (idx)
      5'd0:    r = 33'sd843314857;
      5'd1:    r = 33'sd497837829;
      5'd2:    r = 33'sd263043837;
      5'd3:    r = 33'sd133525159;
      5'd4:    r = 33'sd67021687;
      5'd5:    r = 33'sd33543516;
      5'd6:    r = 33'sd16775851;
      5'd7:    r = 33'sd8388437;
      5'd8:    r = 33'sd4194283;
      5'd9:    r = 33'sd2097149;
      5'd10:   r = 33'sd1048576;
      5'd11:   r = 33'sd524288;
      5'd12:   r = 33'sd262144;
      5'd13:   r = 33'sd131072;
      5'd14:   r = 33'sd65536;
      5'd15:   r = 33'sd32768;
      5'd16:   r = 33'sd16384;
      5'd17:   r = 33'sd8192;
      5'd18:   r = 33'sd4096;
      5'd19:   r = 33'sd2048;
      5'd20:   r = 33'sd1024;
      5'd21:   r = 33'sd512;
      5'd22:   r = 33'sd256;
      5'd23:   r = 33'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // wrap an angle sum into (-pi, pi]
  function automatic logic signed [AngW-1:0] wrap_angle(input logic signed [SumW-1:0] a);
    logic signed [18:0] w;
    logic signed [18:0] r;
    w = 19'(a);
    if (w > 19'sd3 * AngPi) begin
      r = w - (AngTwoPi <<< 1);
    end else if (w > AngPi) begin
      r = w - AngTwoPi;
    end else if (w <= -(19'sd3 * AngPi)) begin
      r = w + (AngTwoPi <<< 1);
    end else if (w <= -AngPi) begin
      r = w + AngTwoPi;
    end else begin
      r = w;
    end
    return r[AngW-1:0];
  endfunction

  function automatic logic signed [CoordW-1:0] sat16(input logic signed [SumW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pacc_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// pacc_cordic_cell
// one cordic rotation step for all three links, registered
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pacc_cordic_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [pacc_pkg::IterW-1:0]   iter_i,
  input  logic                         valid_i,
  input  pacc_pkg::lanes_t             lanes_i,
  output logic                         valid_o,
  output pacc_pkg::lanes_t             lanes_o
);
  import pacc_pkg::*;

  logic   valid_q;
  lanes_t lanes_d, lanes_q;
  logic signed [CfW-1:0] atan_v;

  assign atan_v = atan_entry(iter_i);

  always_comb begin
    logic signed [CfW-1:0] dx;
    logic signed [CfW-1:0] dy;
    lanes_d = lanes_i;
    for (int l = 0; l < NumLanes; l++) begin
      dx = lanes_i[l].y >>> iter_i;
      dy = lanes_i[l].x >>> iter_i;
      if (!lanes_i[l].z[CfW-1]) begin
        lanes_d[l].x = lanes_i[l].x - dx;
        lanes_d[l].y = lanes_i[l].y + dy;
        lanes_d[l].z = lanes_i[l].z - atan_v;
      end else begin
        lanes_d[l].x = lanes_i[l].x + dx;
        lanes_d[l].y = lanes_i[l].y - dy;
        lanes_d[l].z = lanes_i[l].z + atan_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

// ===== rtl/planar_arm_collision_check.sv =====
// path: stages a and b, the cordic chain, then stages m, p and c; stage c registers done_o with the result
// throughput: one request per cycle; busy_o is never raised, done_o cannot be held off
// the depth is set by the cordic chain, one cell per iteration, plus five stages
// reset: control and configuration registers return to their reset values at once
// ---------------------------------------------------------------------------
// planar_arm_collision_check
// forward kinematics of a planar three-link arm and collision test of each
// link against four configured rectangles grown by half the link width
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "planar_arm_collision_check_defines.svh"

module planar_arm_collision_check (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [pacc_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [pacc_pkg::CfgW-1:0]            cfg_wdata_i,
  // request
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [pacc_pkg::AngW-1:0]     angle_1_i,
  input  logic signed [pacc_pkg::AngW-1:0]     angle_2_i,
  input  logic signed [pacc_pkg::AngW-1:0]     angle_3_i,
  // result
  output logic                                 done_o,
  output logic                                 state_valid_o,
  output logic [1:0]                           hit_link_o,
  output logic [1:0]                           hit_obstacle_o,
  output logic signed [pacc_pkg::CoordW-1:0]   joint1_x_o,
  output logic signed [pacc_pkg::CoordW-1:0]   joint1_y_o,
  output logic signed [pacc_pkg::CoordW-1:0]   joint2_x_o,
  output logic signed [pacc_pkg::CoordW-1:0]   joint2_y_o,
  output logic signed [pacc_pkg::CoordW-1:0]   tip_x_o,
  output logic signed [pacc_pkg::CoordW-1:0]   tip_y_o
);
  import pacc_pkg::*;

  localparam int Latency = CordicIterations + 5;

  // fully pipelined, so a request is taken every cycle
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [CfgW-1:0]  obst_q [NumObst];
  logic [LenW-1:0]  len_q  [NumLanes];
  logic [LenW-1:0]  width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obst_q[0] <= 64'h2000_2000_1000_1000;
      obst_q[1] <= 64'h4000_4000_3000_3000;
      obst_q[2] <= 64'h1800_3000_0800_2000;
      obst_q[3] <= 64'h3800_2800_2800_1800;
      len_q[0]  <= 13'd4096;
      len_q[1]  <= 13'd4096;
      len_q[2]  <= 13'd4096;
      width_q   <= 13'd410;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        RegObst0: obst_q[0] <= cfg_wdata_i;
        RegObst1: obst_q[1] <= cfg_wdata_i;
        RegObst2: obst_q[2] <= cfg_wdata_i;
        RegObst3: obst_q[3] <= cfg_wdata_i;
        RegLen1:  len_q[0]  <= cfg_wdata_i[LenW-1:0];
        RegLen2:  len_q[1]  <= cfg_wdata_i[LenW-1:0];
        RegLen3:  len_q[2]  <= cfg_wdata_i[LenW-1:0];
        RegWidth: width_q   <= cfg_wdata_i[LenW-1:0];
        default:  ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage a: absolute angle of each link
  // ---------------------------------------------------------------------
  logic                    va_q;
  logic signed [SumW-1:0]  sum_q [NumLanes];
  logic signed [SumW-1:0]  sum_d [NumLanes];

  always_comb begin
    sum_d[0] = SumW'(angle_1_i);
    sum_d[1] = sum_d[0] + SumW'(angle_2_i);
    sum_d[2] = sum_d[1] + SumW'(angle_3_i);
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumLanes; l++) begin
      sum_q[l] <= sum_d[l];
    end
  end

  // ---------------------------------------------------------------------
  // stage b: wrap to (-pi, pi], fold into the right half plane and seed the cordic
  // ---------------------------------------------------------------------
  logic   vb_q;
  lanes_t seed_d, seed_q;

  always_comb begin
    logic signed [AngW-1:0] r;
    logic signed [18:0]     f;
    for (int l = 0; l < NumLanes; l++) begin
      r = wrap_angle(sum_q[l]);
      f = 19'(r);
      seed_d[l].neg = 1'b0;
      if (f > AngHalfPi) begin
        f = f - AngPi;
        seed_d[l].neg = 1'b1;
      end else if (f < -AngHalfPi) begin
        f = f + AngPi;
        seed_d[l].neg = 1'b1;
      end
      seed_d[l].x = CfGain;
      seed_d[l].y = '0;
      seed_d[l].z = CfW'(f) <<< 17;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q <= seed_d;
  end

  // ---------------------------------------------------------------------
  // cordic chain, one cell per iteration
  // ---------------------------------------------------------------------
  logic   chain_v [CordicIterations+1];
  lanes_t chain_l [CordicIterations+1];

  assign chain_v[0] = vb_q;
  assign chain_l[0] = seed_q;

  for (genvar i = 0; i < CordicIterations; i++) begin : g_cell
    pacc_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .iter_i  (IterW'(i)),
      .valid_i (chain_v[i]),
      .lanes_i (chain_l[i]),
      .valid_o (chain_v[i+1]),
      .lanes_o (chain_l[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // stage m: scale cos and sin by the link length, round half up
  // ---------------------------------------------------------------------
  logic                    vm_q;
  logic signed [SumW-2:0]  tx_q [NumLanes];
  logic signed [SumW-2:0]  ty_q [NumLanes];

  always_ff @(posedge clk_i) begin
    logic signed [CfW-1:0]          c;
    logic signed [CfW-1:0]          s;
    logic signed [CfW+LenW:0]       px;
    logic signed [CfW+LenW:0]       py;
    lane_t                          ln;
    for (int l = 0; l < NumLanes; l++) begin
      ln = chain_l[CordicIterations][l];
      c  = ln.neg ? -ln.x : ln.x;
      s  = ln.neg ? -ln.y : ln.y;
      px = $signed({1'b0, len_q[l]}) * c + ((CfW+LenW+1)'(1) <<< (CfShift - 1));
      py = $signed({1'b0, len_q[l]}) * s + ((CfW+LenW+1)'(1) <<< (CfShift - 1));
      tx_q[l] <= px[CfShift +: SumW-1];
      ty_q[l] <= py[CfShift +: SumW-1];
    end
  end

  // ---------------------------------------------------------------------
  // stage p: saturating joint sums
  // ---------------------------------------------------------------------
  logic                     vp_q;
  logic signed [CoordW-1:0] jx_q [NumLanes];
  logic signed [CoordW-1:0] jy_q [NumLanes];

  always_ff @(posedge clk_i) begin
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    ax = '0;
    ay = '0;
    for (int l = 0; l < NumLanes; l++) begin
      ax = sat16(SumW'(ax) + SumW'(tx_q[l]));
      ay = sat16(SumW'(ay) + SumW'(ty_q[l]));
      jx_q[l] <= ax;
      jy_q[l] <= ay;
    end
  end

  // ---------------------------------------------------------------------
  // stage c: bounding box overlap, first hit from base link and obstacle 0
  // ---------------------------------------------------------------------
  logic                      hit [NumLanes][NumObst];
  logic signed [CoordW-1:0]  ex [NumLanes+1];
  logic signed [CoordW-1:0]  ey [NumLanes+1];

  always_comb begin
    ex[0] = '0;
    ey[0] = '0;
    for (int l = 0; l < NumLanes; l++) begin
      ex[l+1] = jx_q[l];
      ey[l+1] = jy_q[l];
    end
  end

  always_comb begin
    logic signed [SumW-1:0] hw;
    logic signed [SumW-1:0] oxmin, oymin, oxmax, oymax;
    logic signed [SumW-1:0] lxmin, lxmax, lymin, lymax;
    hw = SumW'({1'b0, width_q[LenW-1:1]});
    for (int k = 0; k < NumLanes; k++) begin
      lxmin = SumW'((ex[k] < ex[k+1]) ? ex[k] : ex[k+1]);
      lxmax = SumW'((ex[k] < ex[k+1]) ? ex[k+1] : ex[k]);
      lymin = SumW'((ey[k] < ey[k+1]) ? ey[k] : ey[k+1]);
      lymax = SumW'((ey[k] < ey[k+1]) ? ey[k+1] : ey[k]);
      for (int o = 0; o < NumObst; o++) begin
        oxmin = SumW'($signed(obst_q[o][15:0]))  - hw;
        oymin = SumW'($signed(obst_q[o][31:16])) - hw;
        oxmax = SumW'($signed(obst_q[o][47:32])) + hw;
        oymax = SumW'($signed(obst_q[o][63:48])) + hw;
        hit[k][o] = (lxmax >= oxmin) && (lxmin <= oxmax) &&
                    (lymax >= oymin) && (lymin <= oymax);
      end
    end
  end

  logic       ok_d;
  logic [1:0] hl_d, ho_d;

  always_comb begin
    ok_d = 1'b1;
    hl_d = '0;
    ho_d = '0;
    for (int k = NumLanes - 1; k >= 0; k--) begin
      for (int o = NumObst - 1; o >= 0; o--) begin
        if (hit[k][o]) begin
          ok_d = 1'b0;
          hl_d = 2'(k);
          ho_d = 2'(o);
        end
      end
    end
  end

  logic done_q;

  always_ff @(posedge clk_i) begin
    state_valid_o  <= ok_d;
    hit_link_o     <= hl_d;
    hit_obstacle_o <= ho_d;
    joint1_x_o     <= jx_q[0];
    joint1_y_o     <= jy_q[0];
    joint2_x_o     <= jx_q[1];
    joint2_y_o     <= jy_q[1];
    tip_x_o        <= jx_q[2];
    tip_y_o        <= jy_q[2];
  end

  // valid flags of the stages around the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vm_q   <= 1'b0;
      vp_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      va_q   <= start_i && !busy_o;
      vb_q   <= va_q;
      vm_q   <= chain_v[CordicIterations];
      vp_q   <= vm_q;
      done_q <= vp_q;
    end
  end

  assign done_o = done_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `PACC_ASSERT_DLY(a_latency, start_i && !busy_o, Latency, done_o, "request lost in pipeline")
  `PACC_ASSERT_IMP(a_valid_zero, done_o && state_valid_o,
                   hit_link_o == 2'd0 && hit_obstacle_o == 2'd0, "hit index set on valid state")
  `PACC_ASSERT_IMP(a_link_range, done_o, hit_link_o != 2'd3, "hit link out of range")

endmodule
